### hdl/ict_pkg.sv
// Package for the interpolating calibration table: beat types, constants, codes.
// No dependencies.
`default_nettype none
package ict_pkg;
  localparam int TABLE_DEPTH = 64;

  localparam logic [1:0] ST_QUERY = 2'd0;
  localparam logic [1:0] ST_STORED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Entry word layout: height, p1x, p1y, p2x, p2y.
  localparam int ENTRY_W = 96;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] height;
    logic signed [15:0] in_p1_x;
    logic signed [15:0] in_p1_y;
    logic signed [15:0] in_p2_x;
    logic signed [15:0] in_p2_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] out_p1_x;
    logic signed [15:0] out_p1_y;
    logic signed [15:0] out_p2_x;
    logic signed [15:0] out_p2_y;
    logic [1:0]         status;
    logic [6:0]         entries_held;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // capture the input beat
    logic rd_lo;       // read address select: 1 = lo index, 0 = scan index
    logic cap_a;       // capture read data as entry A (lo / clamp entry)
    logic cap_b;       // capture read data as entry B (hi / current)
    logic wr_en;       // write memory
    logic wr_new;      // write the new entry (else the entry on the read port)
    logic div_start;   // start the serial divider (lo entry on the read port)
    logic lerp_step;   // advance the interpolation coordinate
  } ict_cmd_t;
endpackage
`default_nettype wire

### hdl/ict_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ict_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/ict_datapath.sv
// Datapath: entry RAM, item registers, serial divider and interpolator.
// Depends on ict_pkg and ict_ram.
`default_nettype none
module ict_datapath #(
  parameter int DEPTH = ict_pkg::TABLE_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire ict_pkg::in_beat_t in_beat,
  input  wire ict_pkg::ict_cmd_t cmd,
  input  wire logic [AW-1:0]     scan_addr,
  input  wire logic [AW-1:0]     lo_addr,
  input  wire logic [AW-1:0]     wr_addr,
  output logic                   op_query,
  output logic                   rd_le,      // read height <= item height
  output logic                   rd_ge,      // read height >= item height
  output logic                   div_busy,
  output logic signed [15:0]     lerp_res [4],
  output logic signed [15:0]     pt_a [4]
);
  ict_pkg::in_beat_t item;
  logic [ict_pkg::ENTRY_W-1:0] rdata;
  logic [ict_pkg::ENTRY_W-1:0] ent_a;
  logic [ict_pkg::ENTRY_W-1:0] ent_b;
  logic [ict_pkg::ENTRY_W-1:0] wdata;
  logic [AW-1:0] raddr;

  // A shift write moves the entry just read up by one place.
  assign raddr = cmd.rd_lo ? lo_addr : scan_addr;
  assign wdata = cmd.wr_new ? {item.height, item.in_p1_x, item.in_p1_y,
                               item.in_p2_x, item.in_p2_y} : rdata;

  ict_ram #(.WIDTH(ict_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(cmd.wr_en), .waddr(wr_addr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign op_query = item.opcode;
  assign rd_le = $signed(rdata[95:64]) <= item.height;
  assign rd_ge = $signed(rdata[95:64]) >= item.height;

  // Item and entry capture registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_beat;
    end
    if (cmd.cap_a) begin
      ent_a <= rdata;
    end
    if (cmd.cap_b) begin
      ent_b <= rdata;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pt_a[k] = ent_a[63-16*k -: 16];
    end
  end

  // Restoring divider: (h - hlo) << 16 over (hhi - hlo), 16 quotient bits.
  // Numerator < denominator holds, so only the low 16 quotient bits are nonzero.
  // The lo entry is taken from the read port in the start cycle.
  logic [32:0] rem;
  logic [32:0] den;
  logic [15:0] quo;
  logic [4:0]  dcnt;
  logic [33:0] trial;
  assign trial = {rem, 1'b0} - {1'b0, den};
  assign div_busy = dcnt != 5'd0;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem  <= 33'(item.height) - 33'($signed(rdata[95:64]));
      den  <= 33'($signed(ent_b[95:64])) - 33'($signed(rdata[95:64]));
      dcnt <= 5'd16;
    end else if (div_busy) begin
      if (!trial[33]) begin
        rem <= trial[32:0];
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= {rem[31:0], 1'b0};
        quo <= {quo[14:0], 1'b0};
      end
      dcnt <= dcnt - 5'd1;
    end
  end

  function automatic logic signed [15:0] pt_b(input logic [1:0] k);
    pt_b = ent_b[63-16*k -: 16];
  endfunction

  // One multiply per cycle, rotating through the four coordinates.
  logic [1:0] lk;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  assign diff = 17'(pt_b(lk)) - 17'(pt_a[lk]);
  assign prod = diff * $signed({1'b0, quo});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      lk <= 2'd0;
    end else if (cmd.lerp_step) begin
      lerp_res[lk] <= pt_a[lk] + 16'(prod >>> 16);
      lk <= lk + 2'd1;
    end
  end
endmodule
`default_nettype wire

### hdl/ict_ctrl.sv
// Controller: sequences insert shifts, the scan for a query and the output beat.
// Depends on ict_pkg.
`default_nettype none
module ict_ctrl #(
  parameter int DEPTH = ict_pkg::TABLE_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ict_pkg::ict_cmd_t       cmd,
  output logic [AW-1:0]           scan_addr,
  output logic [AW-1:0]           lo_addr,
  output logic [AW-1:0]           wr_addr,
  input  wire logic               op_query,
  input  wire logic               rd_le,
  input  wire logic               rd_ge,
  input  wire logic               div_busy,
  input  wire logic signed [15:0] lerp_res [4],
  input  wire logic signed [15:0] pt_a [4],
  output ict_pkg::out_beat_t      out_beat
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SHRD = 4'd2;  // insert: read entry at idx-1
  localparam logic [3:0] S_SHCK = 4'd3;  // insert: compare, shift or place
  localparam logic [3:0] S_QRD  = 4'd4;  // query: read entry idx
  localparam logic [3:0] S_QCK  = 4'd5;  // query: compare
  localparam logic [3:0] S_LORD = 4'd6;  // read lo entry
  localparam logic [3:0] S_LOCP = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_LERP = 4'd9;
  localparam logic [3:0] S_CLMP = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;   // insert: hole position; query: scan index
  logic [2:0] lcnt;

  assign in_ready  = state == S_IDLE && !out_valid;
  assign scan_addr = state == S_SHRD ? AW'(idx - CW'(1)) : AW'(idx);
  assign lo_addr   = AW'(idx - CW'(1));
  assign wr_addr   = AW'(idx);

  // Command decode. In the insert compare cycle the entry below the hole is
  // either moved up into the hole or the new entry is placed there.
  always_comb begin
    cmd = '0;
    cmd.load_item = in_valid && in_ready;
    case (state)
      S_SHCK: begin
        cmd.cap_a = 1'b1;
        cmd.wr_en = 1'b1;
        if (idx == CW'(0) || rd_le) begin
          cmd.wr_new = 1'b1;
        end
      end
      S_LORD: cmd.rd_lo = 1'b1;
      S_LOCP: begin
        cmd.cap_a = 1'b1;
        cmd.div_start = 1'b1;
      end
      S_QCK: begin
        cmd.cap_a = 1'b1;
        cmd.cap_b = 1'b1;
      end
      S_LERP: cmd.lerp_step = lcnt != 3'd4;
      default: ;
    endcase
  end

  // Next state. A query clamps to the first entry when the height is at or
  // below it, clamps to the last entry when no held height lies above the
  // item height, and otherwise interpolates below the first larger entry.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid && in_ready) state_next = S_DISP;
      S_DISP: begin
        if (!op_query) begin
          state_next = count == CW'(DEPTH) ? S_OUT :
                       (count == CW'(0) ? S_SHCK : S_SHRD);
        end else begin
          state_next = count == CW'(0) ? S_OUT : S_QRD;
        end
      end
      S_SHRD: state_next = S_SHCK;
      S_SHCK: state_next = (idx == CW'(0) || rd_le) ? S_OUT : S_SHRD;
      S_QRD:  state_next = S_QCK;
      S_QCK: begin
        if (idx == CW'(0) && rd_ge) state_next = S_CLMP;
        else if (!rd_le) state_next = S_LORD;
        else if (idx == count - CW'(1)) state_next = S_CLMP;
        else state_next = S_QRD;
      end
      S_LORD: state_next = S_LOCP;
      S_LOCP: state_next = S_DIV;
      S_DIV:  state_next = div_busy ? S_DIV : S_LERP;
      S_LERP: state_next = lcnt == 3'd4 ? S_OUT : S_LERP;
      S_CLMP: state_next = S_OUT;
      S_OUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State, counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      lcnt      <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_DISP: begin
          idx <= op_query ? CW'(0) : count;
          out_beat <= '0;
        end
        S_SHCK: begin
          if (idx == CW'(0) || rd_le) begin
            count <= count + CW'(1);
            out_beat.status <= ict_pkg::ST_STORED;
          end else begin
            idx <= idx - CW'(1);
          end
        end
        S_QCK: begin
          // Move on while the entry is below the height (or at it, past the first) and not the last.
          if (!(idx == CW'(0) && rd_ge) && rd_le && idx != count - CW'(1)) begin
            idx <= idx + CW'(1);
          end
        end
        S_LOCP: lcnt <= '0;
        S_LERP: lcnt <= lcnt + 3'd1;
        S_OUT: begin
          out_valid <= 1'b1;
          out_beat.entries_held <= 7'(count);
          if (!op_query && count == CW'(DEPTH) && out_beat.status != ict_pkg::ST_STORED)
            out_beat.status <= ict_pkg::ST_FULL;
          else if (op_query && count == CW'(0))
            out_beat.status <= ict_pkg::ST_EMPTY;
        end
        default: ;
      endcase
      if (state == S_LERP && lcnt == 3'd4) begin
        out_beat.out_p1_x <= lerp_res[0];
        out_beat.out_p1_y <= lerp_res[1];
        out_beat.out_p2_x <= lerp_res[2];
        out_beat.out_p2_y <= lerp_res[3];
        out_beat.status   <= ict_pkg::ST_QUERY;
      end
      if (state == S_CLMP) begin
        out_beat.out_p1_x <= pt_a[0];
        out_beat.out_p1_y <= pt_a[1];
        out_beat.out_p2_x <= pt_a[2];
        out_beat.out_p2_y <= pt_a[3];
        out_beat.status   <= ict_pkg::ST_QUERY;
      end
    end
  end
endmodule
`default_nettype wire

### hdl/interpolating_calibration_table.sv
// Top level of the interpolating calibration table.
// Depends on ict_pkg, ict_ctrl, ict_datapath and ict_ram.
//
// Usage: one input beat (valid/ready) gives exactly one output beat.
// An add (opcode 0) inserts the entry after all entries of equal or lower
// height, walking down from the top and moving each larger entry up by one.
// A query (opcode 1) scans entries upward from the first. An interior height
// then reads the lower entry, runs a 16-step restoring divide for the Q0.16
// ratio and uses one shared multiplier for the four coordinates. One item is
// in flight at a time; the next input beat is taken in the cycle after the
// output beat at the earliest.
// Reset clears the entry count and the controller state but not the RAM;
// the RAM contents are never read before written. The result waits in an
// output register while the receiver stalls, and no new item is taken until
// it has been taken.
`default_nettype none
module interpolating_calibration_table #(
  parameter int TABLE_DEPTH = ict_pkg::TABLE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ict_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ict_pkg::out_beat_t      out_data
);
  localparam int AW = $clog2(TABLE_DEPTH);

  ict_pkg::ict_cmd_t cmd;
  logic [AW-1:0] scan_addr;
  logic [AW-1:0] lo_addr;
  logic [AW-1:0] wr_addr;
  logic op_query;
  logic rd_le;
  logic rd_ge;
  logic div_busy;
  logic signed [15:0] lerp_res [4];
  logic signed [15:0] pt_a [4];

  ict_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd),
    .scan_addr(scan_addr), .lo_addr(lo_addr), .wr_addr(wr_addr),
    .op_query(op_query), .rd_le(rd_le), .rd_ge(rd_ge), .div_busy(div_busy),
    .lerp_res(lerp_res), .pt_a(pt_a), .out_beat(out_data)
  );

  ict_datapath #(.DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .in_beat(in_data), .cmd(cmd), .scan_addr(scan_addr),
    .lo_addr(lo_addr), .wr_addr(wr_addr), .op_query(op_query),
    .rd_le(rd_le), .rd_ge(rd_ge), .div_busy(div_busy), .lerp_res(lerp_res),
    .pt_a(pt_a)
  );
endmodule
`default_nettype wire

### sim/tb_interpolating_calibration_table.sv
// Testbench for the interpolating calibration table: random and directed adds and queries,
// each result checked against a behavioral table model kept in the bench.
// Depends on ict_pkg and interpolating_calibration_table.
`default_nettype none
module tb_interpolating_calibration_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ict_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ict_pkg::out_beat_t out_data;

  interpolating_calibration_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Model of the table contents.
  logic signed [31:0] cal_height [ict_pkg::TABLE_DEPTH];
  logic signed [15:0] cal_pts [ict_pkg::TABLE_DEPTH][4];
  int cal_count = 0;

  ict_pkg::in_beat_t pending_beats[$];
  ict_pkg::out_beat_t expected_results[$];
  bit failed = 0;
  bit calm_phase = 0;
  bit stim_done = 0;

  // Append helpers for the two queues.
  function automatic void add_pending(ict_pkg::in_beat_t b);
    pending_beats = {pending_beats, b};
  endfunction

  function automatic void add_expected(ict_pkg::out_beat_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic logic signed [15:0] blend(logic signed [15:0] lo, logic signed [15:0] hi,
                                               longint ratio);
    longint prod;
    prod = (longint'(hi) - longint'(lo)) * ratio;
    return 16'(longint'(lo) + (prod >>> 16));
  endfunction

  // Update the table model with one accepted beat and return the expected result.
  function automatic ict_pkg::out_beat_t apply_item(ict_pkg::in_beat_t b);
    ict_pkg::out_beat_t r;
    int pos, hi, lo;
    longint hlo, hhi, ratio;
    r = '0;
    if (b.opcode == ict_pkg::OP_ADD) begin
      if (cal_count >= ict_pkg::TABLE_DEPTH) begin
        r.status = ict_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < cal_count && cal_height[pos] <= b.height) pos++;
        for (int i = cal_count; i > pos; i--) begin
          cal_height[i] = cal_height[i-1];
          for (int k = 0; k < 4; k++) cal_pts[i][k] = cal_pts[i-1][k];
        end
        cal_height[pos] = b.height;
        cal_pts[pos][0] = b.in_p1_x;
        cal_pts[pos][1] = b.in_p1_y;
        cal_pts[pos][2] = b.in_p2_x;
        cal_pts[pos][3] = b.in_p2_y;
        cal_count++;
        r.status = ict_pkg::ST_STORED;
      end
    end else if (cal_count == 0) begin
      r.status = ict_pkg::ST_EMPTY;
    end else begin
      r.status = ict_pkg::ST_QUERY;
      if (b.height <= cal_height[0] || b.height >= cal_height[cal_count-1]) begin
        pos = (b.height <= cal_height[0]) ? 0 : cal_count - 1;
        r.out_p1_x = cal_pts[pos][0];
        r.out_p1_y = cal_pts[pos][1];
        r.out_p2_x = cal_pts[pos][2];
        r.out_p2_y = cal_pts[pos][3];
      end else begin
        hi = 1;
        while (hi < cal_count - 1 && cal_height[hi] <= b.height) hi++;
        lo = hi - 1;
        hlo = cal_height[lo];
        hhi = cal_height[hi];
        ratio = ((longint'(b.height) - hlo) <<< 16) / (hhi - hlo);
        r.out_p1_x = blend(cal_pts[lo][0], cal_pts[hi][0], ratio);
        r.out_p1_y = blend(cal_pts[lo][1], cal_pts[hi][1], ratio);
        r.out_p2_x = blend(cal_pts[lo][2], cal_pts[hi][2], ratio);
        r.out_p2_y = blend(cal_pts[lo][3], cal_pts[hi][3], ratio);
      end
    end
    r.entries_held = 7'(cal_count);
    return r;
  endfunction

  function automatic ict_pkg::in_beat_t make_beat(logic op, logic signed [31:0] h);
    ict_pkg::in_beat_t b;
    b.opcode = op;
    b.height = h;
    b.in_p1_x = 16'($urandom);
    b.in_p1_y = 16'($urandom);
    b.in_p2_x = 16'($urandom);
    b.in_p2_y = 16'($urandom);
    return b;
  endfunction

  // Heights mostly from a small pool so equal heights and tight spans show up.
  function automatic logic signed [31:0] pick_height();
    case ($urandom_range(0, 5))
      0: return 32'($urandom);
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      default: return 32'(($urandom_range(0, 40) - 20) * 65536 + $urandom_range(0, 3));
    endcase
  endfunction

  // Stimulus: directed beats, then random rounds that fill, overflow and query the table.
  initial begin
    add_pending(make_beat(ict_pkg::OP_QUERY, 32'sh0));
    add_pending(make_beat(ict_pkg::OP_ADD, 32'sh0001_0000));
    add_pending(make_beat(ict_pkg::OP_QUERY, 32'sh8000_0000));
    add_pending(make_beat(ict_pkg::OP_QUERY, 32'sh7fff_ffff));
    add_pending(make_beat(ict_pkg::OP_ADD, 32'sh8000_0000));
    add_pending(make_beat(ict_pkg::OP_ADD, 32'sh7fff_ffff));
    add_pending('{ict_pkg::OP_ADD, 32'sh0001_0000,
                  16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
    add_pending('{ict_pkg::OP_ADD, 32'sh0003_0000,
                  16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
    add_pending(make_beat(ict_pkg::OP_QUERY, 32'sh0001_0000));
    add_pending(make_beat(ict_pkg::OP_QUERY, 32'sh0002_0000));
    add_pending(make_beat(ict_pkg::OP_QUERY, 32'sh0002_ffff));
    add_pending(make_beat(ict_pkg::OP_QUERY, 32'sh8000_0001));
    add_pending(make_beat(ict_pkg::OP_QUERY, 32'sh7fff_fffe));
    add_pending(make_beat(ict_pkg::OP_QUERY, 32'sh0000_0000));
    // Fill the table to capacity, then overflow it.
    for (int i = 0; i < 60; i++) add_pending(make_beat(ict_pkg::OP_ADD, pick_height()));
    for (int i = 0; i < 3; i++) add_pending(make_beat(ict_pkg::OP_ADD, pick_height()));
    for (int i = 0; i < 8; i++) add_pending(make_beat(ict_pkg::OP_QUERY, pick_height()));
    while (pending_beats.size() > 0 || expected_results.size() > 0) @(posedge clk);
    // Random part on the full table.
    for (int i = 0; i < 300; i++)
      add_pending(make_beat(($urandom_range(0, 4) != 0) ? ict_pkg::OP_QUERY : ict_pkg::OP_ADD,
                            pick_height()));
    for (int i = 0; i < 60; i++)
      add_pending(make_beat(ict_pkg::OP_QUERY, pick_height()));
    while (pending_beats.size() > 20) @(posedge clk);
    calm_phase = 1;
    stim_done = 1;
  end

  // Reset, released on a falling clock edge.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Beats presented by the driver and beats accepted by the block.
  int sent_count = 0;
  int accepted_count = 0;

  // Input driver with random idle bursts.
  int in_idle = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && sent_count != accepted_count) begin
        // Holding the beat until accepted.
      end else if (in_idle > 0) begin
        in_idle <= in_idle - 1;
        in_valid <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        in_idle <= $urandom_range(1, 17);
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
        sent_count <= sent_count + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output ready with random stall bursts.
  int out_stall = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
        out_stall <= $urandom_range(1, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on input beats, compare on output beats.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    ict_pkg::out_beat_t want;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid && in_ready) begin
        add_expected(apply_item(in_data));
        accepted_count <= accepted_count + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $realtime, out_data);
          failed = 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch, expected %h actual %h", $realtime, want, out_data);
            failed = 1;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    while (pending_beats.size() > 0 || expected_results.size() > 0 || in_valid) begin
      @(posedge clk);
    end
    repeat (300) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
